>>> hdl/b32d_pkg.sv
package b32d_pkg;

    localparam int MAX_OUT_BYTES_DEF = 80;
    localparam int MAX_CHARS_DEF     = 512;

    localparam int SYM_COUNT = 32;
    localparam int SYM_BITS  = 5;
    localparam int BYTE_BITS = 8;
    localparam int CNT_BITS  = 7;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_CHAR = 2'd1,
        ST_TOO_LONG = 2'd2
    } t_status;

    typedef logic [BYTE_BITS-1:0] t_sym_table [SYM_COUNT];

    // Symbol table: entry k holds the character whose value is k.
    localparam t_sym_table SYM_TABLE = '{
        8'h71, 8'h70, 8'h7A, 8'h72, 8'h79, 8'h39, 8'h78, 8'h38,  // q p z r y 9 x 8
        8'h67, 8'h66, 8'h32, 8'h74, 8'h76, 8'h64, 8'h77, 8'h30,  // g f 2 t v d w 0
        8'h73, 8'h33, 8'h6A, 8'h6E, 8'h35, 8'h34, 8'h6B, 8'h68,  // s 3 j n 5 4 k h
        8'h63, 8'h65, 8'h36, 8'h6D, 8'h75, 8'h61, 8'h37, 8'h6C   // c e 6 m u a 7 l
    };

    typedef struct packed {
        logic [BYTE_BITS-1:0] char_code;
        logic                 last_char;
    } t_in_word;

    typedef struct packed {
        logic [BYTE_BITS-1:0] byte_value;
        logic                 byte_valid;
        logic                 end_of_string;
        t_status              status;
        logic [CNT_BITS-1:0]  byte_count;
    } t_out_word;

endpackage

>>> hdl/b32d_sym_lut.sv
module b32d_sym_lut (
    input  logic [7:0] i_char,
    output logic [4:0] o_value,
    output logic       o_hit
);
    import b32d_pkg::*;

    logic [BYTE_BITS-1:0] folded;

    // Fold A..Z to a..z; codes of 128 and up never match the table.
    always_comb begin
        if (i_char >= 8'h41 && i_char <= 8'h5A) begin
            folded = i_char + 8'h20;
        end else begin
            folded = i_char;
        end
    end

    always_comb begin
        o_value = '0;
        o_hit   = 1'b0;
        for (int k = 0; k < SYM_COUNT; k++) begin
            if (folded == SYM_TABLE[k]) begin
                o_value = SYM_BITS'(k);
                o_hit   = 1'b1;
            end
        end
    end

endmodule

>>> hdl/base32_char_to_byte_decoder.sv
// Base32 (bech32 alphabet) character-to-byte decoder.
// Input channel: one character word per handshake (i_in_valid / o_in_ready)
// carrying the raw character code and a flag that marks the last character
// of an address string. Output channel: one result word per character
// (o_out_valid / i_out_ready) carrying the byte completed by that character,
// if any, the end-of-string flag, the sticky status of the string and the
// running byte count.
// The result of a character is registered and shown in the cycle after it is
// accepted. Throughput is one character per cycle unless the receiver stalls;
// the path is the alphabet compare, a small shift and the bit and byte
// counters, all between the input pins and the result register.
// A new character is taken while the result register is empty or is being
// drained in the same cycle, so a stalled receiver holds the current result
// and back-pressures the sender without losing anything.
// Reset (synchronous, active low) empties the result register and clears the
// bit accumulator, the character and byte counters and the status. All of
// these but the result register clear after the last character of a string.
module base32_char_to_byte_decoder #(
    parameter int MAX_OUT_BYTES = b32d_pkg::MAX_OUT_BYTES_DEF,
    parameter int MAX_CHARS     = b32d_pkg::MAX_CHARS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  b32d_pkg::t_in_word i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output b32d_pkg::t_out_word o_out_word
);
    import b32d_pkg::*;

    localparam int CHAR_W = $clog2(MAX_CHARS);
    localparam logic [CHAR_W-1:0]   CHARS_LAST = CHAR_W'(MAX_CHARS - 1);
    localparam logic [CNT_BITS-1:0] BYTES_CAP  = CNT_BITS'(MAX_OUT_BYTES);

    // Per-string state.
    logic [6:0]          r_store;
    logic [2:0]          r_held;
    logic [CHAR_W-1:0]   r_chars;
    logic [CNT_BITS-1:0] r_bytes;
    t_status             r_status;

    logic [6:0]          n_store;
    logic [2:0]          n_held;
    logic [CHAR_W-1:0]   n_chars;
    logic [CNT_BITS-1:0] n_bytes;
    t_status             n_status;

    logic      r_out_valid;
    t_out_word r_out_word;
    t_out_word n_out_word;

    logic       in_fire;
    logic [4:0] sym_value;
    logic       sym_hit;
    logic       too_long;
    logic [11:0] acc;
    logic [3:0]  total;
    logic [2:0]  rest;

    b32d_sym_lut u_sym_lut (
        .i_char  (i_in_word.char_code),
        .o_value (sym_value),
        .o_hit   (sym_hit)
    );

    // The result register frees up when it is empty or drains this cycle.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    assign too_long = (r_chars == CHARS_LAST);
    assign acc      = {r_store, sym_value};
    assign total    = {1'b0, r_held} + 4'd5;

    always_comb begin
        n_store  = r_store;
        n_held   = r_held;
        n_bytes  = r_bytes;
        n_chars  = too_long ? CHARS_LAST : r_chars + 1'b1;
        rest     = '0;

        n_out_word               = '0;
        n_out_word.end_of_string = i_in_word.last_char;

        // A too-long string overrides a bad character; both are sticky.
        if (too_long) begin
            n_status = ST_TOO_LONG;
        end else if (!sym_hit && r_status == ST_OK) begin
            n_status = ST_BAD_CHAR;
        end else begin
            n_status = r_status;
        end

        // Once the string is in error the accumulator freezes.
        if (n_status == ST_OK) begin
            if (total >= 4'd8) begin
                rest = 3'(total - 4'd8);
                if (r_bytes < BYTES_CAP) begin
                    n_out_word.byte_value = 8'(acc >> rest);
                    n_out_word.byte_valid = 1'b1;
                    n_bytes               = r_bytes + 1'b1;
                end
            end else begin
                rest = total[2:0];
            end
            n_store = acc[6:0] & ~(7'h7F << rest);
            n_held  = rest;
        end

        n_out_word.status     = n_status;
        n_out_word.byte_count = n_bytes;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_store     <= '0;
            r_held      <= '0;
            r_chars     <= '0;
            r_bytes     <= '0;
            r_status    <= ST_OK;
        end else begin
            if (in_fire) begin
                r_out_valid <= 1'b1;
                if (i_in_word.last_char) begin
                    // The string is done: start the next one from scratch.
                    r_store  <= '0;
                    r_held   <= '0;
                    r_chars  <= '0;
                    r_bytes  <= '0;
                    r_status <= ST_OK;
                end else begin
                    r_store  <= n_store;
                    r_held   <= n_held;
                    r_chars  <= n_chars;
                    r_bytes  <= n_bytes;
                    r_status <= n_status;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

>>> hdl/b32d_checker.sv
module b32d_checker #(
    parameter int MAX_OUT_BYTES = b32d_pkg::MAX_OUT_BYTES_DEF
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input b32d_pkg::t_out_word o_out_word
);
    import b32d_pkg::*;

    localparam logic [CNT_BITS-1:0] BYTES_CAP = CNT_BITS'(MAX_OUT_BYTES);

    // Reset leaves no stale result behind.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("stalled result changed or dropped");

    // An empty result register always takes a new word.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled while output empty");

    // Bytes only come out of a string that is still clean.
    a_byte_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.byte_valid |-> o_out_word.status == ST_OK)
        else $error("byte emitted in a string in error");

    // The running count never passes the cap.
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_word.byte_count <= BYTES_CAP)
        else $error("byte count above cap");

endmodule

bind base32_char_to_byte_decoder b32d_checker #(
    .MAX_OUT_BYTES (MAX_OUT_BYTES)
) u_b32d_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);
